// ----- rtl/mmcp_pkg.sv -----
package mmcp_pkg;

	localparam int MESSAGE_BYTES_DEF = 31;
	localparam int TIMEOUT_W         = 16;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;
	localparam int READING_W         = 27;
	localparam int HELD_W            = 5;

	// Byte positions that carry reading digits.
	localparam int POS_FIRST_DIGIT = 7;
	localparam int POS_END_DIGITS  = 13;
	localparam int POS_TENTHS_A    = 27;
	localparam int POS_TENTHS_B    = 28;

	localparam logic [6:0] CHAR_MASK  = 7'h7F;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_NINE  = 7'h39;

	typedef enum logic {
		REQ_BYTE = 1'b0,
		REQ_TICK = 1'b1
	} req_kind_t;

	typedef enum logic {
		ST_COMPLETE = 1'b0,
		ST_TIMEOUT  = 1'b1
	} status_t;

	typedef struct packed {
		req_kind_t  req_type;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		status_t                status;
		logic [READING_W-1:0]   reading_tenths;
		logic                   parity_error;
		logic                   digit_error;
		logic [HELD_W-1:0]      bytes_held;
	} result_t;

endpackage

// ----- rtl/mmcp_if.sv -----
interface mmcp_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;

	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface mmcp_res_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [26:0] reading_tenths;
	logic        parity_error;
	logic        digit_error;
	logic [4:0]  bytes_held;

	modport source (output valid, output status, output reading_tenths,
		output parity_error, output digit_error, output bytes_held, input ready);
	modport sink   (input valid, input status, input reading_tenths,
		input parity_error, input digit_error, input bytes_held, output ready);
endinterface

// ----- rtl/mmcp_in_stage.sv -----
module mmcp_in_stage
	import mmcp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  item_valid,
	output item_t item
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ready   = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- rtl/mmcp_parse.sv -----
module mmcp_parse
	import mmcp_pkg::*;
#(
	parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_go,
	input  item_t                item,
	input  logic [TIMEOUT_W-1:0] timeout_ticks,
	output logic                 result_go,
	output result_t              result
);

	localparam int CNT_W = $clog2(MESSAGE_BYTES + 1);

	logic [CNT_W-1:0]     byte_count_q, byte_count_n, count_plus;
	logic [TIMEOUT_W-1:0] idle_count_q, idle_count_n, idle_inc;
	logic [READING_W-1:0] acc_q, acc_n, acc_times10;
	logic                 parity_q, parity_n, nondigit_q, nondigit_n;
	logic [6:0]           char_val;
	logic                 is_digit, in_field, byte_parity;
	logic [3:0]           digit;

	assign char_val    = item.rx_byte[6:0] & CHAR_MASK;
	assign is_digit    = (char_val >= CHAR_ZERO) && (char_val <= CHAR_NINE);
	assign digit       = is_digit ? char_val[3:0] : 4'd0;
	assign byte_parity = ^item.rx_byte;
	assign in_field    = ((byte_count_q >= CNT_W'(POS_FIRST_DIGIT))
		&& (byte_count_q < CNT_W'(POS_END_DIGITS)))
		|| (byte_count_q == CNT_W'(POS_TENTHS_A))
		|| (byte_count_q == CNT_W'(POS_TENTHS_B));
	// Times ten as two shifted copies; the sum wraps at the reading width.
	assign acc_times10 = {acc_q[READING_W-4:0], 3'b000} + {acc_q[READING_W-2:0], 1'b0};
	assign count_plus  = byte_count_q + CNT_W'(1);
	assign idle_inc    = (idle_count_q != '1) ? idle_count_q + TIMEOUT_W'(1) : idle_count_q;

	always_comb begin
		byte_count_n          = byte_count_q;
		idle_count_n          = idle_count_q;
		acc_n                 = acc_q;
		parity_n              = parity_q;
		nondigit_n            = nondigit_q;
		result_go             = 1'b0;
		result.status         = ST_COMPLETE;
		result.reading_tenths = acc_q;
		result.parity_error   = parity_q;
		result.digit_error    = nondigit_q;
		result.bytes_held     = byte_count_q[HELD_W-1:0];
		if (item_go) begin
			unique case (item.req_type)
				REQ_TICK: begin
					if ((byte_count_q != '0) && (idle_inc > timeout_ticks)) begin
						result_go     = 1'b1;
						result.status = ST_TIMEOUT;
						byte_count_n  = '0;
						idle_count_n  = '0;
						acc_n         = '0;
						parity_n      = 1'b0;
						nondigit_n    = 1'b0;
					end else begin
						idle_count_n = idle_inc;
					end
				end
				REQ_BYTE: begin
					idle_count_n = '0;
					parity_n     = parity_q | byte_parity;
					if (in_field) begin
						acc_n      = acc_times10 + READING_W'(digit);
						nondigit_n = nondigit_q | !is_digit;
					end
					byte_count_n = count_plus;
					if (count_plus == CNT_W'(MESSAGE_BYTES)) begin
						result_go             = 1'b1;
						result.status         = ST_COMPLETE;
						result.reading_tenths = acc_n;
						result.parity_error   = parity_n;
						result.digit_error    = nondigit_n;
						result.bytes_held     = count_plus[HELD_W-1:0];
						byte_count_n          = '0;
						acc_n                 = '0;
						parity_n              = 1'b0;
						nondigit_n            = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			idle_count_q <= '0;
			acc_q        <= '0;
			parity_q     <= 1'b0;
			nondigit_q   <= 1'b0;
		end else begin
			byte_count_q <= byte_count_n;
			idle_count_q <= idle_count_n;
			acc_q        <= acc_n;
			parity_q     <= parity_n;
			nondigit_q   <= nondigit_n;
		end
	end

endmodule

// ----- rtl/mmcp_out_stage.sv -----
module mmcp_out_stage
	import mmcp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    result_go,
	input  result_t result,
	output logic    advance,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_result
);

	logic    valid_q;
	result_t result_q;

	// The register may take a new result when empty or when its current one leaves.
	assign advance    = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= result_go;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result_go) begin
			result_q <= result;
		end
	end

endmodule

// ----- rtl/meter_message_capture_parse_top.sv -----
// Channel  Role    Payload
// req      sink    req_type, rx_byte
// res      source  status, reading_tenths, parity_error, digit_error, bytes_held
// cfg      write   cfg_wr_data (timeout_ticks) when cfg_wr_en is high
//
// One item is accepted per cycle while req is ready. Each item passes an input
// register, then the parse logic, which updates the message state and may load
// the result register; a result is valid on res once it is in that register.
// Reset clears the message state, the valid flags and sets the timeout to 500.
// A stalled result holds the result register; req stays ready as long as the
// input register can move into the parse step.
module meter_message_capture_parse_top
	import mmcp_pkg::*;
#(
	parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mmcp_req_if.sink             req,
	mmcp_res_if.source           res,
	input  logic                 cfg_wr_en,
	input  logic [TIMEOUT_W-1:0] cfg_wr_data
);

	logic                 advance, item_valid, item_go, result_go, req_ready;
	item_t                in_item, item;
	result_t              result, out_result;
	logic [TIMEOUT_W-1:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	assign in_item.req_type = req_kind_t'(req.req_type);
	assign in_item.rx_byte  = req.rx_byte;
	assign req.ready        = req_ready;

	mmcp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req_ready),
		.in_item    (in_item),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	assign item_go = item_valid && advance;

	mmcp_parse #(
		.MESSAGE_BYTES (MESSAGE_BYTES)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_go       (item_go),
		.item          (item),
		.timeout_ticks (timeout_q),
		.result_go     (result_go),
		.result        (result)
	);

	mmcp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.result_go  (result_go),
		.result     (result),
		.advance    (advance),
		.out_valid  (res.valid),
		.out_ready  (res.ready),
		.out_result (out_result)
	);

	assign res.status         = out_result.status;
	assign res.reading_tenths = out_result.reading_tenths;
	assign res.parity_error   = out_result.parity_error;
	assign res.digit_error    = out_result.digit_error;
	assign res.bytes_held     = out_result.bytes_held;

	// A complete message always holds the full byte count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.status == ST_COMPLETE)) |->
			(res.bytes_held == HELD_W'(MESSAGE_BYTES)))
		else $error("complete message with wrong byte count");

	// The input side only stalls behind a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (res.valid && !res.ready))
		else $error("input stalled without output back-pressure");

	// A result is only loaded by an item that was in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_go |-> item_go)
		else $error("result produced without an item");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import mmcp_pkg::*;

	localparam int MSG_BYTES       = MESSAGE_BYTES_DEF;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int QUIET_LIMIT     = 5000;
	localparam int TICK_BURST_CAP  = 600;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [TIMEOUT_W-1:0] cfg_wr_data;

	mmcp_req_if req_ch();
	mmcp_res_if res_ch();

	meter_message_capture_parse_top #(.MESSAGE_BYTES(MSG_BYTES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	function automatic bit reading_position(int pos);
		return (pos >= POS_FIRST_DIGIT && pos < POS_END_DIGITS) ||
			pos == POS_TENTHS_A || pos == POS_TENTHS_B;
	endfunction

	class meter_reading_board;
		bit [TIMEOUT_W-1:0] timeout_ticks;
		int                 byte_count;
		bit [15:0]          idle_count;
		bit [READING_W-1:0] reading;
		bit                 parity_seen;
		bit                 nondigit_seen;
		result_t            readings_due[$];
		int                 errors;

		function new();
			timeout_ticks = TIMEOUT_RESET;
			errors = 0;
			clear_message();
		endfunction

		function void clear_message();
			byte_count = 0;
			idle_count = 0;
			reading = 0;
			parity_seen = 0;
			nondigit_seen = 0;
		endfunction

		function int pending();
			return readings_due.size();
		endfunction

		// Updates the message state for one accepted transaction and queues the
		// result that it causes, if any.
		function void parse_accepted(item_t it);
			result_t r;
			bit [6:0] c;
			int pos;
			bit emit;
			emit = 0;
			if (it.req_type == REQ_TICK) begin
				if (idle_count != 16'hFFFF)
					idle_count++;
				if (byte_count != 0 && idle_count > timeout_ticks) begin
					r.status = ST_TIMEOUT;
					emit = 1;
				end
			end else begin
				pos = byte_count;
				c = it.rx_byte[6:0] & CHAR_MASK;
				idle_count = 0;
				if (^it.rx_byte)
					parity_seen = 1;
				if (reading_position(pos)) begin
					// A non-digit still shifts the reading, as a zero digit.
					if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
						reading = READING_W'(reading * 10 + (c - CHAR_ZERO));
					end else begin
						reading = READING_W'(reading * 10);
						nondigit_seen = 1;
					end
				end
				byte_count = pos + 1;
				if (byte_count >= MSG_BYTES) begin
					r.status = ST_COMPLETE;
					emit = 1;
				end
			end
			if (emit) begin
				r.reading_tenths = reading;
				r.parity_error = parity_seen;
				r.digit_error = nondigit_seen;
				r.bytes_held = byte_count[HELD_W-1:0];
				readings_due.push_back(r);
				clear_message();
			end
		endfunction

		function void compare_field(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (readings_due.size() == 0) begin
				$display("%0t: result with none expected: expected none, actual %p", $time, got);
				errors++;
				return;
			end
			want = readings_due.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("reading_tenths", want.reading_tenths, got.reading_tenths);
			compare_field("parity_error", want.parity_error, got.parity_error);
			compare_field("digit_error", want.digit_error, got.digit_error);
			compare_field("bytes_held", want.bytes_held, got.bytes_held);
		endfunction
	endclass

	meter_reading_board board;
	item_t outgoing_items[$];
	bit sender_fast;
	bit hold_off_pending;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [7:0] framed(logic [6:0] c, bit good_parity);
		return {good_parity ? ^c : ~^c, c};
	endfunction

	function automatic void queue_byte(logic [7:0] b);
		item_t it;
		it.req_type = REQ_BYTE;
		it.rx_byte = b;
		outgoing_items.push_back(it);
	endfunction

	function automatic void queue_ticks(int n);
		item_t it;
		repeat (n) begin
			it.req_type = REQ_TICK;
			it.rx_byte = 8'($urandom_range(0, 255));
			outgoing_items.push_back(it);
		end
	endfunction

	// A clean message carries digits at every reading position and even parity
	// throughout; otherwise a few bytes are damaged. Short tick runs that stay
	// within the timeout may fall between bytes.
	function automatic void queue_message(int count, bit clean);
		logic [6:0] c;
		int pos;
		int max_gap;
		max_gap = board.timeout_ticks < 3 ? board.timeout_ticks : 3;
		for (pos = 0; pos < count; pos++) begin
			if (reading_position(pos) && (clean || $urandom_range(0, 7) != 0))
				c = 7'(CHAR_ZERO + $urandom_range(0, 9));
			else
				c = 7'($urandom_range(0, 127));
			queue_byte(framed(c, clean || $urandom_range(0, 15) != 0));
			if (pos + 1 < count && max_gap > 0 && $urandom_range(0, 7) == 0)
				queue_ticks($urandom_range(1, max_gap));
		end
	endfunction

	function automatic void queue_random(int budget);
		item_t it;
		int ticks;
		while (outgoing_items.size() < budget) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					queue_message(MSG_BYTES, $urandom_range(0, 2) != 0);
				end
				6, 7: begin
					queue_message($urandom_range(1, MSG_BYTES - 1), $urandom_range(0, 1) != 0);
					ticks = board.timeout_ticks + $urandom_range(1, 3);
					queue_ticks(ticks > TICK_BURST_CAP ? TICK_BURST_CAP : ticks);
				end
				8: begin
					repeat ($urandom_range(1, 8)) begin
						it.req_type = req_kind_t'($urandom_range(0, 1));
						it.rx_byte = 8'($urandom_range(0, 255));
						outgoing_items.push_back(it);
					end
				end
				default: begin
					queue_ticks($urandom_range(1, 5));
				end
			endcase
		end
	endfunction

	task automatic drive_items();
		item_t it;
		int gap;
		int n;
		bit calm;
		n = 0;
		calm = 0;
		while (outgoing_items.size() != 0) begin
			it = outgoing_items.pop_front();
			if (n % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			gap = (sender_fast || calm) ? 0 : $urandom_range(0, 10);
			n++;
			@(negedge clk);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			req_ch.valid <= 1'b1;
			req_ch.req_type <= it.req_type;
			req_ch.rx_byte <= it.rx_byte;
			do @(posedge clk); while (!req_ch.ready);
			board.parse_accepted(it);
		end
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	// The register is only written once all results are in and the last
	// transaction has had time to leave the parse stage.
	task automatic set_timeout(logic [TIMEOUT_W-1:0] value);
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		board.timeout_ticks = value;
	endtask

	initial begin
		int stall;
		int taken;
		bit calm;
		result_t got;
		res_ch.ready = 1'b0;
		taken = 0;
		calm = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 32 == 0)
				calm = ($urandom_range(0, 3) == 0);
			stall = calm ? 0 : $urandom_range(0, 10);
			if (hold_off_pending) begin
				hold_off_pending = 0;
				stall = HOLD_OFF_CYCLES;
			end
			@(negedge clk);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			got.status = status_t'(res_ch.status);
			got.reading_tenths = res_ch.reading_tenths;
			got.parity_error = res_ch.parity_error;
			got.digit_error = res_ch.digit_error;
			got.bytes_held = res_ch.bytes_held;
			board.check_result(got);
			taken++;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("meter_message_capture_parse_top regression: fail");
		$finish;
	end

	initial begin
		int pos;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_BYTE;
		req_ch.rx_byte = 8'h00;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		sender_fast = 0;
		hold_off_pending = 0;
		board = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Ticks with nothing held, then a message with the largest reading and
		// the byte extremes at the other positions.
		queue_ticks(3);
		for (pos = 0; pos < MSG_BYTES; pos++) begin
			if (reading_position(pos))
				queue_byte(framed(CHAR_NINE, 1));
			else
				queue_byte(pos % 2 ? 8'hFF : 8'h00);
		end
		drive_items();

		// Odd parity, characters just outside the digit range, then a timeout.
		set_timeout(16'd2);
		queue_byte(8'h80);
		queue_byte(8'h7F);
		for (pos = 2; pos < POS_FIRST_DIGIT; pos++)
			queue_byte(framed(7'($urandom_range(0, 127)), 1));
		queue_byte(framed(7'h2F, 1));
		queue_byte(framed(7'h3A, 1));
		queue_ticks(3);
		drive_items();
		queue_random(200);
		drive_items();

		// With a zero timeout every byte and tick pair yields a result, so a long
		// hold on the result side backs the block up into its input.
		set_timeout(16'd0);
		repeat (60) begin
			queue_byte(8'($urandom_range(0, 255)));
			queue_ticks(1);
		end
		sender_fast = 1;
		hold_off_pending = 1;
		drive_items();
		sender_fast = 0;
		queue_random(150);
		queue_ticks(1);
		drive_items();
		queue_random(200);
		drive_items();

		set_timeout(TIMEOUT_RESET);
		queue_random(300);
		drive_items();
		set_timeout(TIMEOUT_W'($urandom_range(1, 20)));
		queue_random(200);
		drive_items();
		set_timeout(TIMEOUT_W'($urandom_range(0, 65535)));
		queue_random(200);
		drive_items();

		while (board.pending() != 0) @(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("meter_message_capture_parse_top regression: pass");
		else
			$display("meter_message_capture_parse_top regression: fail");
		$finish;
	end

endmodule
